// File: sv/jsu_pkg.sv
// shared types, constants and helper functions for the json string unescaper
package jsu_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);

  localparam logic [6:0] U8_ACCEPT = 7'd0;
  localparam logic [6:0] U8_REJECT = 7'd12;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [15:0] SUR_HI_LO = 16'hD800;
  localparam logic [15:0] SUR_HI_HI = 16'hDBFF;
  localparam logic [15:0] SUR_LO_LO = 16'hDC00;
  localparam logic [15:0] SUR_LO_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [6:0] U8_NEXT [0:107] = '{
    7'd0, 7'd12, 7'd24, 7'd36, 7'd60, 7'd96, 7'd84, 7'd12, 7'd12, 7'd12, 7'd48, 7'd72,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd0, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd0, 7'd12, 7'd0, 7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12
  };

  typedef enum logic [3:0] {
    M_STD, M_ESC, M_U1, M_U2, M_U3, M_U4, M_SKIP, M_SUR1, M_SUR2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_MALFORMED  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [23:0] byte_count;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  // work handed from the parser to the serializer
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_status;
    status_t         status;
    logic [23:0]     byte_count;
  } job_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80) c = 4'd0;
    else if (b < 8'h90) c = 4'd1;
    else if (b < 8'hA0) c = 4'd9;
    else if (b < 8'hC0) c = 4'd7;
    else if (b < 8'hC2) c = 4'd8;
    else if (b < 8'hE0) c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0) c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4) c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else c = 4'd8;
    return c;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) h = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) h = 5'(c - 8'h37);
    else h = 5'd16;
    return h;
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= 21'h7F) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.n = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// File: sv/jsu_front.sv
// front end: escape parser, utf-8 automaton and byte counter, one item per cycle while take is high
module jsu_front #(
  parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  jsu_pkg::in_item_t item,
  output logic             job_push,
  output jsu_pkg::job_t    job
);
  import jsu_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [6:0]            u8_r, u8_nxt;
  logic [15:0]           acc_r, acc_nxt;
  logic [15:0]           hi_r, hi_nxt;
  logic                  pp_r, pp_nxt;
  logic                  err_r, err_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [7:0]            b;
  logic [6:0]            u8_step;
  logic [4:0]            h;
  logic [15:0]           v;
  logic                  do_plain;
  logic                  do_enc;
  logic [20:0]           enc_cp;
  enc_t                  enc;
  logic [2:0]            nb;
  logic [3:0][7:0]       bytes;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [COUNT_BITS-1:0] cnt_new;
  status_t               st;

  assign b       = item.in_byte;
  assign u8_step = U8_NEXT[u8_r + {3'b000, byte_class(b)}];
  assign h       = hex_value(b);
  assign v       = {acc_r[11:0], h[3:0]};
  assign enc     = utf8_encode(enc_cp);

  always_comb begin
    mode_nxt = mode_r;
    u8_nxt   = u8_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    pp_nxt   = pp_r;
    err_nxt  = err_r;
    do_plain = 1'b0;
    do_enc   = 1'b0;
    enc_cp   = '0;
    nb       = 3'd0;
    bytes    = '0;
    if (item.has_byte && !err_r) begin
      unique case (mode_r) inside
        M_STD: do_plain = 1'b1;
        M_SKIP: begin
          if (b != CH_SPACE) begin
            mode_nxt = M_STD;
            do_plain = 1'b1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STD;
          unique case (b) inside
            CH_BSLASH, CH_SLASH, CH_QUOTE: begin
              nb = 3'd1;
              bytes[0] = b;
            end
            CH_LF: begin
              nb = 3'd1;
              bytes[0] = CH_LF;
              mode_nxt = M_SKIP;
            end
            CH_B: begin
              nb = 3'd1;
              bytes[0] = CH_BS;
            end
            CH_F: begin
              nb = 3'd1;
              bytes[0] = CH_FF;
            end
            CH_N: begin
              nb = 3'd1;
              bytes[0] = CH_LF;
            end
            CH_R: begin
              nb = 3'd1;
              bytes[0] = CH_CR;
            end
            CH_T: begin
              nb = 3'd1;
              bytes[0] = CH_TAB;
            end
            CH_U: mode_nxt = M_U1;
            default: err_nxt = 1'b1;
          endcase
        end
        M_U1, M_U2, M_U3: begin
          if (h[4]) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = (mode_r == M_U1) ? {12'h000, h[3:0]} : v;
            mode_nxt = (mode_r == M_U1) ? M_U2 : ((mode_r == M_U2) ? M_U3 : M_U4);
          end
        end
        M_U4: begin
          if (h[4]) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = v;
            mode_nxt = M_STD;
            if (pp_r) begin
              if (v < SUR_LO_LO || v > SUR_LO_HI) begin
                err_nxt = 1'b1;
              end else begin
                pp_nxt = 1'b0;
                do_enc = 1'b1;
                enc_cp = SUPP_BASE + {1'b0, hi_r[9:0], v[9:0]};
              end
            end else if (v >= SUR_HI_LO && v <= SUR_HI_HI) begin
              hi_nxt = v;
              pp_nxt = 1'b1;
              mode_nxt = M_SUR1;
            end else if (v >= SUR_LO_LO && v <= SUR_LO_HI) begin
              err_nxt = 1'b1;
            end else begin
              do_enc = 1'b1;
              enc_cp = {5'b00000, v};
            end
          end
        end
        M_SUR1: begin
          if (b == CH_BSLASH) mode_nxt = M_SUR2;
          else err_nxt = 1'b1;
        end
        M_SUR2: begin
          if (b == CH_U) mode_nxt = M_U1;
          else err_nxt = 1'b1;
        end
        default: err_nxt = 1'b1;
      endcase
      if (do_plain) begin
        u8_nxt = u8_step;
        if (u8_step == U8_REJECT) begin
          err_nxt = 1'b1;
        end else if (b == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          nb = 3'd1;
          bytes[0] = b;
        end
      end
      if (do_enc) begin
        nb = enc.n;
        bytes = enc.b;
      end
    end

    // saturating add of this item's output bytes
    cnt_sum = {1'b0, cnt_r} + (COUNT_BITS + 1)'(nb);
    cnt_new = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
    cnt_nxt = cnt_new;

    if (err_nxt) st = ST_MALFORMED;
    else if (mode_nxt == M_STD || mode_nxt == M_SKIP)
      st = (u8_nxt == U8_ACCEPT) ? ST_OK : ST_INCOMPLETE;
    else st = ST_MALFORMED;

    if (item.end_of_string) begin
      mode_nxt = M_STD;
      u8_nxt   = U8_ACCEPT;
      acc_nxt  = '0;
      hi_nxt   = '0;
      pp_nxt   = 1'b0;
      err_nxt  = 1'b0;
      cnt_nxt  = '0;
    end

    job.nbytes     = nb;
    job.bytes      = bytes;
    job.has_status = item.end_of_string;
    job.status     = st;
    job.byte_count = 24'(cnt_new);
    job_push       = take && (nb != 3'd0 || item.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_STD;
      u8_r   <= U8_ACCEPT;
      acc_r  <= '0;
      hi_r   <= '0;
      pp_r   <= 1'b0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      u8_r   <= u8_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
      pp_r   <= pp_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: sv/jsu_job_fifo.sv
// short job queue between the parser and the serializer
module jsu_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::job_t wr_data,
  input  logic          rd_en,
  output jsu_pkg::job_t rd_data,
  output logic          full,
  output logic          empty
);
  import jsu_pkg::*;

  job_t                  mem_r [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_PTR_BITS:0]   cnt_r;
  logic                    do_wr, do_rd;

  assign full    = (cnt_r == (JOB_PTR_BITS + 1)'(JOB_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: sv/jsu_back.sv
// back end: serializes each job into result items through an output register
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  out_item_t  out_r, out_nxt;
  logic       out_valid_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic       load;
  logic       last;

  assign total = job.nbytes + {2'b00, job.has_status};
  assign last  = (idx_r == total - 3'd1);
  assign load  = job_valid && (!out_valid_r || pop);
  assign job_pop = load && last;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    out_nxt.last_of_run = last;
    if (idx_r < job.nbytes) begin
      out_nxt.out_byte   = job.bytes[idx_r[1:0]];
      out_nxt.is_status  = 1'b0;
      out_nxt.status     = ST_OK;
      out_nxt.byte_count = '0;
    end else begin
      out_nxt.out_byte   = '0;
      out_nxt.is_status  = 1'b1;
      out_nxt.status     = job.status;
      out_nxt.byte_count = job.byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= last ? 3'd0 : idx_r + 3'd1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: sv/json_string_unescape_utf8_unit.sv
// json string-body unescaper with utf-8 validation, top level
// path: an item's results pass through the job queue and then the output register
// throughput: one input item per cycle while the four-job queue is not full; results leave
// at one per cycle while pop is high
// reset: synchronous active-low rst_n clears parser state, counter, queue pointers and output valid
module json_string_unescape_utf8_unit #(
  parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  jsu_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  logic take;
  logic job_push;
  job_t job_in;
  job_t job_head;
  logic job_pop;
  logic fifo_empty;

  assign take = push && !full;

  jsu_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  jsu_job_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_head),
    .full    (full),
    .empty   (fifo_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .job_valid (!fifo_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // the serializer only retires a job that is in the queue
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !fifo_empty)
    else $error("job retired from empty queue");

  // a status item always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.is_status) |-> out_data.last_of_run)
    else $error("status item not last of run");

  // byte items carry no status and no count
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.is_status) |-> (out_data.byte_count == '0 && out_data.status == ST_OK))
    else $error("byte item with status fields");

  // a waiting result that is not taken stays on the ports
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!empty && !pop) && $past(rst_n)) |-> (!empty && $stable(out_data)))
    else $error("waiting result changed");
`endif

endmodule
